// File: sv/reserved_expansion_field_parser_macros.svh
// ---------------------------------------------------------------------------
// reserved expansion field parser assertion macros
// shared property wrappers for the port-level checker
// ---------------------------------------------------------------------------
`ifndef RESERVED_EXPANSION_FIELD_PARSER_MACROS_SVH
`define RESERVED_EXPANSION_FIELD_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RXF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rxf same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define RXF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rxf next-cycle check failed");

`endif

// File: sv/rxf_pkg.sv
// ---------------------------------------------------------------------------
// rxf_pkg
// types, constants and subfield size table of the expansion field parser
// ---------------------------------------------------------------------------
package rxf_pkg;

    localparam logic [7:0] CAT_PARSED = 8'd21;
    localparam logic [3:0] NONE_BIT   = 4'd8;
    localparam logic [8:0] SEEN_MAX   = 9'd257;
    localparam logic [7:0] MIN_LENGTH = 8'd2;

    typedef enum logic [2:0] {
        ROLE_LENGTH     = 3'd0,
        ROLE_BITMAP     = 3'd1,
        ROLE_SUBFIELD   = 3'd2,
        ROLE_UNUSED     = 3'd3,
        ROLE_NOT_PARSED = 3'd4
    } t_role;

    typedef enum logic [1:0] {
        PART_MAIN      = 2'd0,
        PART_EXTENSION = 2'd1,
        PART_REMAINDER = 2'd2
    } t_part;

    typedef struct packed {
        logic [8:0] seen;      // octets seen, saturating
        logic [7:0] decl_len;  // declared length
        logic [7:0] spec;      // primary subfield bitmap
        logic [3:0] next_bit;  // owning bitmap bit, NONE_BIT when idle
        logic [7:0] payload;   // payload octets left
        t_part      phase;
        logic [7:0] part_pos;
        logic [7:0] mask;      // entries recorded so far
        logic [7:0] cat;       // held category
    } t_state;

    localparam t_state STATE_RESET = '{
        seen:     9'd0,
        decl_len: 8'd0,
        spec:     8'd0,
        next_bit: NONE_BIT,
        payload:  8'd0,
        phase:    PART_MAIN,
        part_pos: 8'd0,
        mask:     8'd0,
        cat:      8'd0
    };

    typedef struct packed {
        logic [7:0] byte_value;
        t_role      role;
        logic [2:0] sub_bit;
        t_part      sub_part;
        logic [7:0] offset;
        logic       end_of_field;
        logic       field_valid;
        logic [7:0] present_mask;
    } t_result;

    // bitmap walk request and answer
    typedef struct packed {
        logic [3:0] start_bit;
        logic [7:0] spec;
        logic [7:0] payload;
        logic [7:0] mask;
    } t_walk_req;

    typedef struct packed {
        logic [3:0] next_bit;
        logic [7:0] mask;
    } t_walk_rsp;

    // main part size of each subfield, indexed by bitmap bit
    function automatic logic [1:0] main_size(input logic [2:0] b);
        logic [1:0] sz;
        case (b)
            3'd0:    sz = 2'd1;  // MES
            3'd1:    sz = 2'd2;  // TNH
            3'd2:    sz = 2'd1;  // STA
            3'd3:    sz = 2'd2;  // SGV
            3'd4:    sz = 2'd1;  // GAO
            3'd5:    sz = 2'd1;  // NAV
            3'd6:    sz = 2'd2;  // SelH
            3'd7:    sz = 2'd2;  // BPS
            default: sz = 2'd1;
        endcase
        return sz;
    endfunction

endpackage

// File: sv/rxf_walk.sv
// ---------------------------------------------------------------------------
// rxf_walk
// bitmap walk: finds the next subfield that starts a part, records entries
// ---------------------------------------------------------------------------
module rxf_walk
    import rxf_pkg::*;
(
    input  t_walk_req i_req,
    output t_walk_rsp o_rsp
);

    logic [3:0] nb;
    logic [7:0] m;
    logic       done;

    always_comb begin
        nb   = i_req.start_bit;
        m    = i_req.mask;
        done = 1'b0;
        // bits only move downward, so one descending sweep covers the walk
        for (int k = 7; k >= 0; k--) begin
            if (!done && nb == 4'(k)) begin
                if (i_req.spec[k]) begin
                    m[k] = 1'b1;
                    if (i_req.payload >= {6'd0, main_size(3'(k))}) begin
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    if (i_req.payload == 8'd0 || k == 0) begin
                        nb = NONE_BIT;
                    end else begin
                        nb = 4'(k - 1);
                    end
                end
            end
        end
        o_rsp.next_bit = nb;
        o_rsp.mask     = m;
    end

endmodule

// File: sv/rxf_tagger.sv
// ---------------------------------------------------------------------------
// rxf_tagger
// per-octet tagging and next parser state, purely combinational
// ---------------------------------------------------------------------------
module rxf_tagger
    import rxf_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_category,
    input  logic       i_last_byte,
    output t_state     o_state,
    output t_result    o_result
);

    t_walk_req  walk_req;
    t_walk_rsp  walk_rsp;
    logic       is_pos0;
    logic       is_pos1;
    logic       parse_ok;
    logic       in_sub;
    logic [2:0] cur_bit;
    logic [7:0] pl_dec;
    logic [1:0] sz;
    logic       finish;
    logic       use_walk;
    logic       walk_valid;
    t_state     nxt;

    assign is_pos0  = (i_state.seen == 9'd0);
    assign is_pos1  = (i_state.seen == 9'd1);
    assign parse_ok = (i_state.cat == CAT_PARSED);
    assign in_sub   = !is_pos0 && !is_pos1 && parse_ok
                      && (i_state.seen < {1'b0, i_state.decl_len})
                      && (i_state.next_bit != NONE_BIT);
    assign cur_bit  = i_state.next_bit[2:0];
    assign pl_dec   = (i_state.payload != 8'd0) ? i_state.payload - 8'd1 : 8'd0;
    assign sz       = main_size(cur_bit);

    // does the current octet close its subfield
    always_comb begin
        finish = 1'b0;
        case (i_state.phase)
            PART_MAIN: begin
                if ({1'b0, i_state.part_pos} + 9'd1 < {7'd0, sz}) begin
                    finish = 1'b0;
                end else if ((cur_bit == 3'd3 || cur_bit == 3'd2) && i_data_byte[0]
                             && pl_dec != 8'd0) begin
                    finish = 1'b0;
                end else if (cur_bit == 3'd0 && pl_dec != 8'd0) begin
                    finish = 1'b0;
                end else begin
                    finish = 1'b1;
                end
            end
            PART_REMAINDER: finish = (pl_dec == 8'd0);
            default:        finish = 1'b1;
        endcase
    end

    assign walk_valid = is_pos1 && parse_ok && (i_state.decl_len >= MIN_LENGTH);
    assign use_walk   = walk_valid || (in_sub && finish);

    always_comb begin
        if (is_pos1) begin
            walk_req.start_bit = 4'd7;
            walk_req.spec      = i_data_byte;
            walk_req.payload   = i_state.decl_len - MIN_LENGTH;
        end else begin
            walk_req.start_bit = (pl_dec == 8'd0 || cur_bit == 3'd0)
                                 ? NONE_BIT : {1'b0, cur_bit - 3'd1};
            walk_req.spec      = i_state.spec;
            walk_req.payload   = pl_dec;
        end
        walk_req.mask = i_state.mask;
    end

    rxf_walk u_walk (
        .i_req (walk_req),
        .o_rsp (walk_rsp)
    );

    always_comb begin
        nxt      = i_state;
        nxt.seen = (i_state.seen < SEEN_MAX) ? i_state.seen + 9'd1 : i_state.seen;

        o_result              = '0;
        o_result.byte_value   = i_data_byte;
        o_result.role         = ROLE_UNUSED;
        o_result.end_of_field = i_last_byte;

        if (is_pos0) begin
            nxt.cat         = i_category;
            nxt.decl_len    = i_data_byte;
            o_result.role   = ROLE_LENGTH;
        end else if (is_pos1) begin
            nxt.spec        = i_data_byte;
            o_result.role   = ROLE_BITMAP;
            if (walk_valid) begin
                nxt.payload = i_state.decl_len - MIN_LENGTH;
            end
        end else if (!parse_ok) begin
            o_result.role   = ROLE_NOT_PARSED;
        end else if (in_sub) begin
            o_result.role     = ROLE_SUBFIELD;
            o_result.sub_bit  = cur_bit;
            o_result.sub_part = i_state.phase;
            o_result.offset   = i_state.part_pos;
            nxt.payload       = pl_dec;
            if (!finish) begin
                if (i_state.phase == PART_MAIN
                    && {1'b0, i_state.part_pos} + 9'd1 >= {7'd0, sz}) begin
                    // main part done, move into extension or remainder
                    nxt.phase    = (cur_bit == 3'd0) ? PART_REMAINDER : PART_EXTENSION;
                    nxt.part_pos = 8'd0;
                end else begin
                    nxt.part_pos = i_state.part_pos + 8'd1;
                end
            end
        end

        if (use_walk) begin
            nxt.next_bit = walk_rsp.next_bit;
            nxt.mask     = walk_rsp.mask;
            nxt.phase    = PART_MAIN;
            nxt.part_pos = 8'd0;
        end

        if (i_last_byte) begin
            if (nxt.cat == CAT_PARSED && nxt.decl_len >= MIN_LENGTH
                && nxt.seen >= {1'b0, nxt.decl_len}) begin
                o_result.field_valid  = 1'b1;
                o_result.present_mask = nxt.mask;
            end
            o_state = STATE_RESET;
        end else begin
            o_state = nxt;
        end
    end

endmodule

// File: sv/reserved_expansion_field_parser.sv
// ---------------------------------------------------------------------------
// reserved_expansion_field_parser
// tags each octet of a category 21 reserved expansion field
// ---------------------------------------------------------------------------
// One octet enters per transaction and one tagged result leaves for it. The
// first octet of a field is the declared length, the second the primary
// subfield bitmap; following octets are assigned to the subfields of the
// set bitmap bits from BPS (bit 7) down to MES (bit 0), with SGV and STA
// taking one extension octet when their FX bit is set and MES taking all
// remaining octets. Octets beyond the declared length are tagged unused and
// octets of other categories are tagged not parsed. The transaction marked
// tlast closes the field, carries the validity flag and the mask of bitmap
// bits that received an entry, and returns the parser to its start state.
// Throughput is one octet per clock unless the result stream stalls: the
// bitmap walk and tag decode sit between the input and result registers, so
// the state loop holds only the state register. Each octet passes the input
// register, then the result register. No clearing pass runs after reset.
module reserved_expansion_field_parser
    import rxf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [7:0]  s_axis_tuser,   // [7:0] category
    input  logic        s_axis_tlast,   // last_byte
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] byte_value, [10:8] subfield_bit,
                                        // [12:11] subfield_part, [20:13] offset_in_part,
                                        // [21] field_valid, [29:22] present_mask, rest zero
    output logic [2:0]  m_axis_tuser,   // [2:0] byte_role
    output logic        m_axis_tlast    // end_of_field
);

    // input register stage
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic [7:0] r_in_cat;
    logic       r_in_last;

    // parser state and result register
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;

    logic       stage_go;

    // the result stage moves whenever its register is empty or being drained
    assign stage_go      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || stage_go;

    rxf_tagger u_tagger (
        .i_state     (r_state),
        .i_data_byte (r_in_data),
        .i_category  (r_in_cat),
        .i_last_byte (r_in_last),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    // control and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (stage_go) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_cat  <= s_axis_tuser;
            r_in_last <= s_axis_tlast;
        end
        if (stage_go && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.end_of_field;
    assign m_axis_tuser  = r_out.role;
    assign m_axis_tdata  = {2'b00, r_out.present_mask, r_out.field_valid, r_out.offset,
                            r_out.sub_part, r_out.sub_bit, r_out.byte_value};

endmodule

// File: sv/rxf_checker.sv
// ---------------------------------------------------------------------------
// rxf_checker
// port-level checks of the expansion field parser, bound to the top level
// ---------------------------------------------------------------------------
`include "reserved_expansion_field_parser_macros.svh"

module rxf_checker
    import rxf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result transaction keeps its content
    `RXF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // subfield tags are zero on octets that belong to no subfield
    `RXF_ASSERT_IMPL(a_tag_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != ROLE_SUBFIELD, m_axis_tdata[20:8] == 13'd0)

    // end-of-field report only on the closing transaction
    `RXF_ASSERT_IMPL(a_report_end, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[29:21] == 9'd0)

    // an invalid field reports no entries
    `RXF_ASSERT_IMPL(a_mask_valid, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[21], m_axis_tdata[29:22] == 8'd0)

endmodule

bind reserved_expansion_field_parser rxf_checker u_rxf_checker (.*);
